// ===== src/kct_pkg.sv =====
// Shared types, constants and helpers of the 4-mer count table block.
package kct_pkg;

    localparam int BIN_COUNT = 256;
    localparam int BIN_W     = 8;
    localparam int IDX_W     = $clog2(BIN_COUNT);
    localparam int CNT_W     = 16;
    localparam int SHARED_W  = 17;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 2;
    localparam int HIST_W    = 3 * CODE_W;

    localparam logic [BIN_W-1:0] BIN_MAX = 8'd255;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_CMP   = 2'd3;

    localparam logic KIND_END = 1'b0;
    localparam logic KIND_CMP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic add;
        logic end_rep;
        logic cmp_start;
        logic clr;
        logic clr_both;
        logic add_wr;
        logic cmp_rd;
        logic out_cmp;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic word_hit;
        logic cnt_last;
        logic out_valid;
    } t_dp_stat;

    function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    endfunction

endpackage

// ===== src/kmer_count_table_and_overlap.sv =====
// Top level of the two-table 4-mer counter with overlap compare.
// Start word: accepted, then a sweep over all 256 bins clears the selected table.
// Add word: accepted alone when no 4-mer forms yet, else followed by a bin read, then a bin write.
// End word: report in the output register the cycle after acceptance.
// Compare word: one bin pair a cycle, both tables read at one shared address, then the report is registered.
// Reset (synchronous, active low) clears all counters, then a sweep over all 256 bins zeroes both tables.
module kmer_count_table_and_overlap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_table_sel,
    input  logic [kct_pkg::SYM_W-1:0]     i_symbol,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_report_kind,
    output logic [kct_pkg::CNT_W-1:0]     o_word_count,
    output logic [kct_pkg::CNT_W-1:0]     o_overflow_count,
    output logic [kct_pkg::SHARED_W-1:0]  o_shared_count,
    output logic                          o_passes,
    input  logic                          i_cfg_we,
    input  logic [kct_pkg::SHARED_W-1:0]  i_cfg_data
);
    import kct_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    kct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    kct_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_table_sel      (i_table_sel),
        .i_symbol         (i_symbol),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_report_kind    (o_report_kind),
        .o_word_count     (o_word_count),
        .o_overflow_count (o_overflow_count),
        .o_shared_count   (o_shared_count),
        .o_passes         (o_passes)
    );

endmodule

// ===== src/kct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/kct_ctrl.sv =====
// Controller state machine: handshake, clearing sweeps, add and compare sequencing.
module kct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic               i_out_ready,
    input  kct_pkg::t_dp_stat  i_stat,
    output kct_pkg::t_dp_cmd   o_cmd
);
    import kct_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_ADD_RD,
        S_ADD_WR,
        S_CMP,
        S_CMP_TAIL,
        S_CMP_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !i_stat.out_valid || i_out_ready;
    // An end word loads the output register at once, so it waits for a free slot.
    assign o_in_ready = (r_state == S_IDLE) && ((i_opcode != OP_END) || w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = w_accept && (i_opcode == OP_START);
        o_cmd.add       = w_accept && (i_opcode == OP_ADD);
        o_cmd.end_rep   = w_accept && (i_opcode == OP_END);
        o_cmd.cmp_start = w_accept && (i_opcode == OP_CMP);
        o_cmd.clr       = (r_state == S_INIT) || (r_state == S_CLR);
        o_cmd.clr_both  = (r_state == S_INIT);
        o_cmd.add_wr    = (r_state == S_ADD_WR);
        o_cmd.cmp_rd    = (r_state == S_CMP);
        o_cmd.out_cmp   = (r_state == S_CMP_OUT) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT, S_CLR: begin
                if (i_stat.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_opcode)
                        OP_START: n_state = S_CLR;
                        OP_ADD:   n_state = i_stat.word_hit ? S_ADD_RD : S_IDLE;
                        OP_END:   n_state = S_IDLE;
                        OP_CMP:   n_state = S_CMP;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD:   n_state = S_ADD_WR;
            S_ADD_WR:   n_state = S_IDLE;
            S_CMP: begin
                if (i_stat.cnt_last) begin
                    n_state = S_CMP_TAIL;
                end
            end
            S_CMP_TAIL: n_state = S_CMP_OUT;
            S_CMP_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WR) |-> ($past(r_state) == S_ADD_RD))
        else $error("bin write without a preceding bin read");

    a_clr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLR) && i_stat.cnt_last) |=> (r_state == S_IDLE))
        else $error("clear sweep did not return to idle");

endmodule

// ===== src/kct_datapath.sv =====
// Datapath: bin memories, per-table counters, compare accumulator and output register.
module kct_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kct_pkg::t_dp_cmd                  i_cmd,
    output kct_pkg::t_dp_stat                 o_stat,
    input  logic                              i_table_sel,
    input  logic [kct_pkg::SYM_W-1:0]         i_symbol,
    input  logic                              i_cfg_we,
    input  logic [kct_pkg::SHARED_W-1:0]      i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_report_kind,
    output logic [kct_pkg::CNT_W-1:0]         o_word_count,
    output logic [kct_pkg::CNT_W-1:0]         o_overflow_count,
    output logic [kct_pkg::SHARED_W-1:0]      o_shared_count,
    output logic                              o_passes
);
    import kct_pkg::*;

    logic [HIST_W-1:0]   r_recent [2];
    logic [1:0]          r_chars  [2];
    logic [CNT_W-1:0]    r_words  [2];
    logic [CNT_W-1:0]    r_ovf    [2];
    logic [SHARED_W-1:0] r_min_shared;
    logic [SHARED_W-1:0] r_acc;
    logic [IDX_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_idx;
    logic                r_tab;
    logic                r_rd_vld;

    logic [CODE_W-1:0]   w_code;
    logic [BIN_W-1:0]    w_rdata [2];
    logic [BIN_W-1:0]    w_rd_sel;
    logic                w_not_full;
    logic [IDX_W-1:0]    w_waddr;
    logic [IDX_W-1:0]    w_raddr;
    logic [BIN_W-1:0]    w_wdata;
    logic [BIN_W-1:0]    w_bin_min;
    logic [CNT_W-1:0]    w_ovf_min;
    logic [SHARED_W-1:0] w_shared;

    // A=0, C=1, T=2, G=3 fall out of bits 2:1 of the ASCII code.
    assign w_code     = i_symbol[2:1];
    assign w_rd_sel   = w_rdata[r_tab];
    assign w_not_full = (w_rd_sel < BIN_MAX);
    assign w_waddr    = i_cmd.clr ? r_cnt : r_idx;
    assign w_raddr    = i_cmd.cmp_rd ? r_cnt : r_idx;
    assign w_wdata    = i_cmd.clr ? '0 : w_rd_sel + 8'd1;
    assign w_bin_min  = (w_rdata[0] < w_rdata[1]) ? w_rdata[0] : w_rdata[1];
    assign w_ovf_min  = (r_ovf[0] < r_ovf[1]) ? r_ovf[0] : r_ovf[1];
    assign w_shared   = r_acc + SHARED_W'(w_ovf_min);

    assign o_stat.word_hit  = (r_chars[i_table_sel] == 2'd3);
    assign o_stat.cnt_last  = &r_cnt;
    assign o_stat.out_valid = o_out_valid;

    for (genvar t = 0; t < 2; t++) begin : g_table
        logic w_we;

        assign w_we = (i_cmd.clr && (i_cmd.clr_both || (r_tab == 1'(t))))
                    || (i_cmd.add_wr && (r_tab == 1'(t)) && w_not_full);

        kct_ram #(
            .WIDTH (BIN_W),
            .DEPTH (BIN_COUNT)
        ) u_bins (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[t])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 2; t++) begin
                r_recent[t] <= '0;
                r_chars[t]  <= '0;
                r_words[t]  <= '0;
                r_ovf[t]    <= '0;
            end
            r_min_shared <= '0;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_tab        <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_shared <= i_cfg_data;
            end

            if (i_cmd.start || i_cmd.cmp_start) begin
                r_cnt <= '0;
            end else if (i_cmd.clr || i_cmd.cmp_rd) begin
                r_cnt <= r_cnt + 8'd1;
            end

            if (i_cmd.start) begin
                r_tab                <= i_table_sel;
                r_recent[i_table_sel] <= '0;
                r_chars[i_table_sel]  <= '0;
                r_words[i_table_sel]  <= '0;
                r_ovf[i_table_sel]    <= '0;
            end

            if (i_cmd.add) begin
                r_tab <= i_table_sel;
                r_recent[i_table_sel] <= {r_recent[i_table_sel][HIST_W-CODE_W-1:0], w_code};
                if (r_chars[i_table_sel] == 2'd3) begin
                    r_idx <= {r_recent[i_table_sel], w_code};
                end else begin
                    r_chars[i_table_sel] <= r_chars[i_table_sel] + 2'd1;
                end
            end

            if (i_cmd.add_wr) begin
                r_words[r_tab] <= sat_inc16(r_words[r_tab]);
                if (!w_not_full) begin
                    r_ovf[r_tab] <= sat_inc16(r_ovf[r_tab]);
                end
            end

            r_rd_vld <= i_cmd.cmp_rd;
            if (i_cmd.cmp_start) begin
                r_acc <= '0;
            end else if (r_rd_vld) begin
                r_acc <= r_acc + SHARED_W'(w_bin_min);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_cmp || i_cmd.end_rep) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_cmp) begin
            o_report_kind    <= KIND_CMP;
            o_word_count     <= '0;
            o_overflow_count <= '0;
            o_shared_count   <= w_shared;
            o_passes         <= (w_shared >= r_min_shared);
        end else if (i_cmd.end_rep) begin
            o_report_kind    <= KIND_END;
            o_word_count     <= r_words[i_table_sel];
            o_overflow_count <= r_ovf[i_table_sel];
            o_shared_count   <= '0;
            o_passes         <= 1'b0;
        end
    end

    a_end_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.end_rep |=> (o_out_valid && (o_report_kind == KIND_END)))
        else $error("end word did not produce an end report");

    a_acc_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && !i_cmd.cmp_start) |=> (r_acc >= $past(r_acc)))
        else $error("shared accumulator wrapped during compare");

endmodule

// ===== verif/kmer_overlap_checker.sv =====
// Checker for the 4-mer count tables: predicts every report and compares it with the block.
`timescale 1ns / 1ps

module kmer_overlap_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_table_sel,
    input  logic [kct_pkg::SYM_W-1:0]     i_symbol,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_report_kind,
    input  logic [kct_pkg::CNT_W-1:0]     i_word_count,
    input  logic [kct_pkg::CNT_W-1:0]     i_overflow_count,
    input  logic [kct_pkg::SHARED_W-1:0]  i_shared_count,
    input  logic                          i_passes,
    input  logic                          i_cfg_we,
    input  logic [kct_pkg::SHARED_W-1:0]  i_cfg_data,
    output int                            o_error_count,
    output int                            o_pending_count,
    output int                            o_report_count
);
    import kct_pkg::*;

    typedef struct packed {
        logic                kind;
        logic [CNT_W-1:0]    words;
        logic [CNT_W-1:0]    ovf;
        logic [SHARED_W-1:0] shared;
        logic                passes;
    } t_report;

    logic [BIN_W-1:0]    bin_tally [2][BIN_COUNT];
    logic [HIST_W-1:0]   code_history [2];
    logic [1:0]          chars_seen [2];
    logic [CNT_W-1:0]    word_tally [2];
    logic [CNT_W-1:0]    overflow_tally [2];
    logic [SHARED_W-1:0] min_shared;
    t_report             expected_reports [$];
    int                  mismatches = 0;
    int                  checked = 0;

    function automatic void clear_tally(input int tbl);
        for (int i = 0; i < BIN_COUNT; i++) begin
            bin_tally[tbl][i] = '0;
        end
        code_history[tbl]   = '0;
        chars_seen[tbl]     = '0;
        word_tally[tbl]     = '0;
        overflow_tally[tbl] = '0;
    endfunction

    function automatic logic [SHARED_W-1:0] overlap_sum();
        int total;
        total = 0;
        for (int i = 0; i < BIN_COUNT; i++) begin
            if (bin_tally[0][i] < bin_tally[1][i]) begin
                total += int'(bin_tally[0][i]);
            end else begin
                total += int'(bin_tally[1][i]);
            end
        end
        if (overflow_tally[0] < overflow_tally[1]) begin
            total += int'(overflow_tally[0]);
        end else begin
            total += int'(overflow_tally[1]);
        end
        return total[SHARED_W-1:0];
    endfunction

    always @(posedge i_clk) begin : track
        t_report          want;
        t_report          got;
        logic [1:0]       code;
        logic [BIN_W-1:0] slot;
        int               tbl;
        if (!i_rst_n) begin
            clear_tally(0);
            clear_tally(1);
            min_shared = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                min_shared = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                tbl = int'(i_table_sel);
                want = '0;
                case (i_opcode)
                    OP_START: clear_tally(tbl);
                    OP_ADD: begin
                        code = i_symbol[2:1];
                        if (chars_seen[tbl] == 2'd3) begin
                            // Oldest code sits in the high bits of the word.
                            slot = {code_history[tbl], code};
                            if (bin_tally[tbl][slot] < BIN_MAX) begin
                                bin_tally[tbl][slot] = bin_tally[tbl][slot] + 8'd1;
                            end else if (overflow_tally[tbl] != CNT_MAX) begin
                                overflow_tally[tbl] = overflow_tally[tbl] + 16'd1;
                            end
                            if (word_tally[tbl] != CNT_MAX) begin
                                word_tally[tbl] = word_tally[tbl] + 16'd1;
                            end
                        end else begin
                            chars_seen[tbl] = chars_seen[tbl] + 2'd1;
                        end
                        code_history[tbl] = {code_history[tbl][HIST_W-3:0], code};
                    end
                    OP_END: begin
                        want.kind  = KIND_END;
                        want.words = word_tally[tbl];
                        want.ovf   = overflow_tally[tbl];
                        expected_reports.push_back(want);
                    end
                    OP_CMP: begin
                        want.kind   = KIND_CMP;
                        want.shared = overlap_sum();
                        want.passes = (want.shared >= min_shared);
                        expected_reports.push_back(want);
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.kind   = i_report_kind;
                got.words  = i_word_count;
                got.ovf    = i_overflow_count;
                got.shared = i_shared_count;
                got.passes = i_passes;
                checked++;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("report %0d arrived with nothing expected: kind %0d", checked,
                                 got.kind);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    if (got.kind !== want.kind || got.words !== want.words ||
                        got.ovf !== want.ovf || got.shared !== want.shared ||
                        got.passes !== want.passes) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"report %0d mismatch: expected kind %0d words %0d",
                                      " ovf %0d shared %0d passes %0d"},
                                     checked, want.kind, want.words, want.ovf, want.shared,
                                     want.passes);
                            $display("    got kind %0d words %0d ovf %0d shared %0d passes %0d",
                                     got.kind, got.words, got.ovf, got.shared, got.passes);
                        end
                    end
                end
            end
        end
        o_pending_count <= expected_reports.size();
        o_error_count   <= mismatches;
        o_report_count  <= checked;
    end

endmodule

// ===== verif/kmer_count_table_and_overlap_tb.sv =====
// Testbench top for the 4-mer count tables: drives words and settings, gives the verdict.
`timescale 1ns / 1ps

module kmer_count_table_and_overlap_tb;
    import kct_pkg::*;

    localparam int IDLE_PCT   = 34;
    localparam int SETTLE     = 300;
    localparam int SAT_LEN    = 300;
    localparam int RAND_ITEMS = 1400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_opcode = OP_START;
    logic                i_table_sel = 1'b0;
    logic [SYM_W-1:0]    i_symbol = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_report_kind;
    logic [CNT_W-1:0]    o_word_count;
    logic [CNT_W-1:0]    o_overflow_count;
    logic [SHARED_W-1:0] o_shared_count;
    logic                o_passes;
    logic                i_cfg_we = 1'b0;
    logic [SHARED_W-1:0] i_cfg_data = '0;

    int   error_count;
    int   pending_reports;
    int   report_count;
    int   words_sent = 0;
    logic steady = 1'b0;

    always #4 i_clk = ~i_clk;

    kmer_count_table_and_overlap dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_table_sel      (i_table_sel),
        .i_symbol         (i_symbol),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_report_kind    (o_report_kind),
        .o_word_count     (o_word_count),
        .o_overflow_count (o_overflow_count),
        .o_shared_count   (o_shared_count),
        .o_passes         (o_passes),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    kmer_overlap_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_table_sel      (i_table_sel),
        .i_symbol         (i_symbol),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_report_kind    (o_report_kind),
        .i_word_count     (o_word_count),
        .i_overflow_count (o_overflow_count),
        .i_shared_count   (o_shared_count),
        .i_passes         (o_passes),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_error_count    (error_count),
        .o_pending_count  (pending_reports),
        .o_report_count   (report_count)
    );

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Holds valid and payload until the word is taken.
    task automatic send_word(input logic [1:0] op, input logic sel, input logic [SYM_W-1:0] sym);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 20 : 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_table_sel <= sel;
        i_symbol    <= sym;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    function automatic logic [SYM_W-1:0] symbol_for(input logic [1:0] code);
        logic [SYM_W-1:0] sym;
        sym = SYM_W'($urandom_range(255));
        sym[2:1] = code;
        return sym;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports != 0);
        // A clear sweep or an add can still be running with nothing expected.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_min_shared(input logic [SHARED_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One sequence with random content, or a single stray word now and then.
    task automatic random_burst();
        logic       sel;
        logic [1:0] c0;
        logic [1:0] c1;
        logic       narrow;
        int         len;
        sel = 1'($urandom_range(1));
        if ($urandom_range(99) < 80) begin
            c0 = 2'($urandom_range(3));
            c1 = 2'($urandom_range(3));
            narrow = 1'($urandom_range(1));
            len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
            if ($urandom_range(99) < 60) begin
                send_word(OP_START, sel, SYM_W'($urandom_range(255)));
            end
            for (int i = 0; i < len; i++) begin
                if (narrow) begin
                    send_word(OP_ADD, sel, symbol_for($urandom_range(1) ? c0 : c1));
                end else begin
                    send_word(OP_ADD, sel, SYM_W'($urandom_range(255)));
                end
            end
            if ($urandom_range(99) < 85) begin
                send_word(OP_END, sel, SYM_W'($urandom_range(255)));
            end
            if ($urandom_range(99) < 25) begin
                send_word(OP_CMP, 1'($urandom_range(1)), SYM_W'($urandom_range(255)));
            end
        end else begin
            send_word(2'($urandom_range(3)), sel, SYM_W'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [SHARED_W-1:0] thresholds [4];
        int                  target;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_min_shared('0);

        // Empty tables, then short sequences around the four-character boundary.
        send_word(OP_CMP, 1'b0, 8'h00);
        send_word(OP_END, 1'b1, 8'hFF);
        send_word(OP_ADD, 1'b0, 8'h00);
        send_word(OP_ADD, 1'b0, 8'hFF);
        send_word(OP_ADD, 1'b0, "A");
        send_word(OP_ADD, 1'b0, "C");
        send_word(OP_ADD, 1'b0, "G");
        send_word(OP_ADD, 1'b0, "T");
        send_word(OP_END, 1'b0, 8'h00);
        // Characters after an end extend the same sequence.
        send_word(OP_ADD, 1'b0, "g");
        send_word(OP_END, 1'b0, 8'h00);
        send_word(OP_ADD, 1'b1, "T");
        send_word(OP_ADD, 1'b1, "G");
        send_word(OP_ADD, 1'b1, "A");
        send_word(OP_ADD, 1'b1, "C");
        send_word(OP_ADD, 1'b1, "G");
        send_word(OP_END, 1'b1, 8'h00);
        send_word(OP_CMP, 1'b1, 8'hFF);
        send_word(OP_START, 1'b0, 8'h00);
        send_word(OP_END, 1'b0, 8'h00);
        send_word(OP_ADD, 1'b0, "a");
        send_word(OP_ADD, 1'b0, "c");
        send_word(OP_ADD, 1'b0, "t");
        send_word(OP_END, 1'b0, 8'h00);
        send_word(OP_CMP, 1'b0, 8'h00);

        // Drive one word into both tables until its bin is full and overflow counts build up.
        set_min_shared(17'h1FFFF);
        steady <= 1'b1;
        send_word(OP_START, 1'b0, 8'h00);
        send_word(OP_START, 1'b1, 8'h00);
        for (int i = 0; i < SAT_LEN; i++) begin
            send_word(OP_ADD, 1'b0, symbol_for(2'd0));
            send_word(OP_ADD, 1'b1, symbol_for(2'd0));
        end
        send_word(OP_END, 1'b0, 8'h00);
        send_word(OP_END, 1'b1, 8'h00);
        send_word(OP_CMP, 1'b0, 8'h00);
        // Sum is one full bin plus an overflow count of 42: check both sides of the threshold.
        set_min_shared(17'd297);
        send_word(OP_CMP, 1'b0, 8'h00);
        set_min_shared(17'd298);
        send_word(OP_CMP, 1'b1, 8'h00);
        steady <= 1'b0;

        thresholds[0] = '0;
        thresholds[1] = 17'h1FFFF;
        thresholds[2] = SHARED_W'($urandom_range(0, 300));
        thresholds[3] = SHARED_W'($urandom_range(0, 3000));
        target = words_sent;
        for (int p = 0; p < 4; p++) begin
            set_min_shared(thresholds[p]);
            target += RAND_ITEMS / 4;
            while (words_sent < target) begin
                random_burst();
            end
        end

        wait_drained();
        $display("%0d words accepted, %0d reports checked, %0d mismatches, %0d reports missing",
                 words_sent, report_count, error_count, pending_reports);
        $display("covered short and random sequences, saturated bins and overflow counts, %s",
                 "thresholds at both extremes");
        if (error_count == 0 && pending_reports == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d reports outstanding", pending_reports);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== kmer_count_table_and_overlap.f =====
src/kct_pkg.sv
src/kct_ram.sv
src/kct_ctrl.sv
src/kct_datapath.sv
src/kmer_count_table_and_overlap.sv
verif/kmer_overlap_checker.sv
verif/kmer_count_table_and_overlap_tb.sv
